FILE: hw/rtl/ags_pkg.sv
// ----------------------------------------------------------------------------
// ags_pkg
// Shared constants, register indexes and types of the alpha bevel shader.
// ----------------------------------------------------------------------------
package ags_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int WIDTH_W     = 12;
   localparam int HEIGHT_W    = 13;
   localparam int ROW_W       = HEIGHT_W + 1;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LIGHT_X      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LIGHT_Y      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LIGHT_GAIN   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_LIGHT_RED    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_LIGHT_GREEN  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_LIGHT_BLUE   = 3'd7;

   // floor(q / 255) for q below 2^17: multiply by ceil(2^26 / 255), shift 26
   localparam logic [18:0] RECIP_255  = 19'd263173;
   localparam int          RECIP_SH   = 26;
   // shading offset kept within +-256 units of 255
   localparam int          SPAN       = 65280;

   typedef struct packed {
      logic signed [15:0] lx;
      logic signed [15:0] ly;
      logic [11:0]        gain;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } light_type;

endpackage

FILE: hw/rtl/alpha_gradient_bevel_shader.sv
// ----------------------------------------------------------------------------
// alpha_gradient_bevel_shader
// Alpha bevel shader over a raster RGBA stream with a 3x3 edge-clamped window.
// ----------------------------------------------------------------------------
// Flow: one item at a time, req_ready low from the store access through the
//   window step and, when it gives a result, shading and output.
// Output: a result is registered after shading and held while rsp_ready
//   stalls; it belongs to the pixel image_width + 1 items earlier.
// Reset: synchronous, clears counters, window, config to defaults; the line
//   stores are not cleared.
module alpha_gradient_bevel_shader (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [7:0]                    req_pix_red,
   input  logic [7:0]                    req_pix_green,
   input  logic [7:0]                    req_pix_blue,
   input  logic [7:0]                    req_pix_alpha,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_out_red,
   output logic [7:0]                    rsp_out_green,
   output logic [7:0]                    rsp_out_blue,
   output logic [7:0]                    rsp_out_alpha,
   output logic                          rsp_frame_last,
   input  logic                          csr_we,
   input  logic [ags_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ags_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ags_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MEM   = 3'd1;
   localparam logic [2:0] S_WIN   = 3'd2;
   localparam logic [2:0] S_SHADE = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   light_type           light_ff;

   logic [ADDR_W-1:0]   cnt_col_ff, cnt_col_in;
   logic [ROW_W-1:0]    cnt_row_ff, cnt_row_in;
   logic [ADDR_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [31:0]         pix_ff, pix_in;
   logic [7:0]          win_ff [9];
   logic [31:0]         centre_ff;
   logic [31:0]         cur_ff;
   logic signed [10:0]  nx_ff, nx_in, ny_ff, ny_in;
   logic                last_ff, last_in;
   logic                start_ff;
   logic                win_valid;

   logic [WIDTH_W-1:0]  w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [31:0]         old_q;
   logic [7:0]          up_q;
   logic [7:0]          newcol [3];

   logic                sh_done;
   logic [7:0]          sh_red, sh_green, sh_blue;
   logic                rsp_valid_ff;
   logic [7:0]          rsp_red_ff, rsp_green_ff, rsp_blue_ff, rsp_alpha_ff;
   logic                rsp_last_ff;
   logic                out_free;

   assign w_eff = (width_ff == '0) ? WIDTH_W'(1) :
                  (width_ff > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= WIDTH_W'(640);
         height_ff      <= HEIGHT_W'(480);
         light_ff.lx    <= 16'sd8192;
         light_ff.ly    <= -16'sd14189;
         light_ff.gain  <= 12'd256;
         light_ff.red   <= 8'd255;
         light_ff.green <= 8'd255;
         light_ff.blue  <= 8'd255;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_ff       <= csr_wdata[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: height_ff      <= csr_wdata[HEIGHT_W-1:0];
            REG_LIGHT_X:      light_ff.lx    <= signed'(csr_wdata);
            REG_LIGHT_Y:      light_ff.ly    <= signed'(csr_wdata);
            REG_LIGHT_GAIN:   light_ff.gain  <= csr_wdata[11:0];
            REG_LIGHT_RED:    light_ff.red   <= csr_wdata[7:0];
            REG_LIGHT_GREEN:  light_ff.green <= csr_wdata[7:0];
            REG_LIGHT_BLUE:   light_ff.blue  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // raster position of the accepted item, with wrap after config changes
   always_comb begin
      col_in = cnt_col_ff;
      row_in = cnt_row_ff;
      if ({1'b0, cnt_col_ff} >= w_eff) begin
         col_in = '0;
         row_in = cnt_row_ff + 1'b1;
      end
      if (row_in > ROW_W'(h_eff) + 1'b1) begin
         col_in = '0;
         row_in = '0;
      end
      pix_in = (row_in < ROW_W'(h_eff)) ?
               {req_pix_alpha, req_pix_blue, req_pix_green, req_pix_red} : 32'd0;
   end

   ags_line_store u_store (
      .clock  (clock),
      .rd_en  (state_ff == S_MEM),
      .addr   (col_ff),
      .pix_we (state_ff == S_MEM),
      .pix_wd (pix_ff),
      .up_we  (state_ff == S_WIN),
      .up_wd  (old_q[31:24]),
      .pix_q  (old_q),
      .up_q   (up_q)
   );

   assign newcol[0] = up_q;
   assign newcol[1] = old_q[31:24];
   assign newcol[2] = pix_ff[31:24];

   // window step: gradients of the centre before this item's column enters
   always_comb begin
      logic [7:0]         a [3][3];
      logic [ADDR_W-1:0]  x;
      logic [ROW_W-1:0]   y;
      logic               right_ok;
      logic signed [10:0] sx, sy;
      right_ok = (col_ff != '0);
      if (right_ok) begin
         win_valid = (row_ff >= ROW_W'(1)) && (row_ff - 1'b1 < ROW_W'(h_eff));
         x = col_ff - 1'b1;
         y = row_ff - 1'b1;
      end else begin
         win_valid = (row_ff >= ROW_W'(2)) && (row_ff - ROW_W'(2) < ROW_W'(h_eff));
         x = ADDR_W'(w_eff - 1'b1);
         y = row_ff - ROW_W'(2);
      end
      for (int i = 0; i < 3; i++) begin
         a[i][1] = win_ff[6+i];
         a[i][0] = (x == '0) ? win_ff[6+i] : win_ff[3+i];
         a[i][2] = right_ok ? newcol[i] : win_ff[6+i];
      end
      for (int i = 0; i < 3; i++) begin
         if (y == '0) a[0][i] = a[1][i];
         if (y == ROW_W'(h_eff) - 1'b1) a[2][i] = a[1][i];
      end
      sx = '0;
      sy = '0;
      for (int i = 0; i < 3; i++) begin
         sx = sx + signed'({3'b0, a[i][2]}) - signed'({3'b0, a[i][0]});
         sy = sy + signed'({3'b0, a[2][i]}) - signed'({3'b0, a[0][i]});
      end
      nx_in = sx;
      ny_in = sy;
      last_in = win_valid && ({1'b0, x} == w_eff - 1'b1) &&
                (y == ROW_W'(h_eff) - 1'b1);
      // advance the raster position
      if (last_in) begin
         cnt_col_in = '0;
         cnt_row_in = '0;
      end else if ({1'b0, col_ff} + 1'b1 >= w_eff) begin
         cnt_col_in = '0;
         cnt_row_in = row_ff + 1'b1;
      end else begin
         cnt_col_in = col_ff + 1'b1;
         cnt_row_in = row_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_MEM;
         S_MEM:   state_in = S_WIN;
         S_WIN:   state_in = win_valid ? S_SHADE : S_IDLE;
         S_SHADE: if (sh_done) state_in = S_OUT;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_col_ff   <= '0;
         cnt_row_ff   <= '0;
         centre_ff    <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         start_ff <= (state_ff == S_WIN) && win_valid;
         if (state_ff == S_WIN) begin
            cnt_col_ff <= cnt_col_in;
            cnt_row_ff <= cnt_row_in;
            centre_ff  <= old_q;
            for (int i = 0; i < 3; i++) begin
               win_ff[i]   <= win_ff[3+i];
               win_ff[3+i] <= win_ff[6+i];
               win_ff[6+i] <= newcol[i];
            end
         end
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_valid && req_ready) begin
         col_ff <= col_in;
         row_ff <= row_in;
         pix_ff <= pix_in;
      end
      if (state_ff == S_WIN) begin
         cur_ff  <= centre_ff;
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         last_ff <= last_in;
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_red_ff   <= sh_red;
         rsp_green_ff <= sh_green;
         rsp_blue_ff  <= sh_blue;
         rsp_alpha_ff <= cur_ff[31:24];
         rsp_last_ff  <= last_ff;
      end
   end

   ags_shade u_shade (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .nx     (nx_ff),
      .ny     (ny_ff),
      .centre (cur_ff),
      .light  (light_ff),
      .done   (sh_done),
      .red    (sh_red),
      .green  (sh_green),
      .blue   (sh_blue)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = rsp_red_ff;
   assign rsp_out_green  = rsp_green_ff;
   assign rsp_out_blue   = rsp_blue_ff;
   assign rsp_out_alpha  = rsp_alpha_ff;
   assign rsp_frame_last = rsp_last_ff;

   logic unused_kind;
   assign unused_kind = req_kind;

   a_done_in_shade: assert property (@(posedge clock) disable iff (reset)
      sh_done |-> state_ff == S_SHADE)
      else $error("shading finished outside its wait state");
   a_accept_to_mem: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_MEM)
      else $error("accepted item did not reach the store access");
   a_mem_to_win: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MEM |=> state_ff == S_WIN)
      else $error("store read not followed by window step");
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MEM |-> {1'b0, col_ff} < w_eff)
      else $error("column outside the row");

endmodule

FILE: hw/rtl/ags_line_store.sv
// ----------------------------------------------------------------------------
// ags_line_store
// Row stores: RGBA of the last row and alpha of the row above it.
// Read-first, registered read outputs.
// ----------------------------------------------------------------------------
module ags_line_store (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [ags_pkg::ADDR_W-1:0] addr,
   input  logic                      pix_we,
   input  logic [31:0]               pix_wd,
   input  logic                      up_we,
   input  logic [7:0]                up_wd,
   output logic [31:0]               pix_q,
   output logic [7:0]                up_q
);
   import ags_pkg::*;

   logic [31:0] pix_mem [MAX_WIDTH];
   logic [7:0]  up_mem  [MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         pix_q <= pix_mem[addr];
      end
      if (pix_we) begin
         pix_mem[addr] <= pix_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         up_q <= up_mem[addr];
      end
      if (up_we) begin
         up_mem[addr] <= up_wd;
      end
   end

endmodule

FILE: hw/rtl/ags_shade.sv
// ----------------------------------------------------------------------------
// ags_shade
// Four-stage shading datapath: light dot product, per-channel scale,
// divide by 255 * 2^22, clamp. Results hold until the next start.
// ----------------------------------------------------------------------------
module ags_shade (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [10:0]  nx,
   input  logic signed [10:0]  ny,
   input  logic [31:0]         centre,
   input  ags_pkg::light_type  light,
   output logic                done,
   output logic [7:0]          red,
   output logic [7:0]          green,
   output logic [7:0]          blue
);
   import ags_pkg::*;

   logic [3:0]         stg_ff, stg_in;
   logic [31:0]        c_ff;
   logic signed [27:0] p_ff, p_in;
   logic [19:0]        lg_ff [3];
   logic [19:0]        lg_in [3];
   logic [17:0]        sh_ff;
   logic signed [48:0] q_ff [3];
   logic signed [48:0] q_in [3];
   logic [35:0]        prod_ff [3];
   logic [35:0]        prod_in [3];
   logic [7:0]         res_ff [3];
   logic [7:0]         res_in [3];
   logic [7:0]         lc [3];

   assign lc[0] = light.red;
   assign lc[1] = light.green;
   assign lc[2] = light.blue;

   always_comb begin
      logic [20:0]        k;
      logic signed [26:0] q1;
      logic signed [26:0] u;
      logic [9:0]         dq;
      logic signed [11:0] s;
      stg_in = {stg_ff[2:0], start};
      p_in = 28'(nx) * 28'(light.lx) + 28'(ny) * 28'(light.ly);
      for (int i = 0; i < 3; i++) begin
         lg_in[i] = 20'(lc[i]) * 20'(light.gain);
         k = (p_ff > 0) ? {1'b0, lg_ff[i]} : {3'b0, sh_ff};
         q_in[i] = 49'(p_ff) * 49'(signed'({1'b0, k}));
         q1 = q_ff[i][48:22];
         if (q1 > 27'sd65280) begin
            q1 = 27'sd65280;
         end else if (q1 < -27'sd65280) begin
            q1 = -27'sd65280;
         end
         u = q1 + 27'(SPAN);
         prod_in[i] = 36'(u[16:0]) * 36'(RECIP_255);
         dq = prod_ff[i][RECIP_SH +: 10];
         s = signed'({4'b0, c_ff[8*i +: 8]}) + signed'({2'b0, dq}) - 12'sd256;
         if (c_ff[31:24] < 8'd3) begin
            res_in[i] = c_ff[8*i +: 8];
         end else if (s < 0) begin
            res_in[i] = 8'd0;
         end else if (s > 12'sd255) begin
            res_in[i] = 8'd255;
         end else begin
            res_in[i] = s[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff <= '0;
      end else begin
         stg_ff <= stg_in;
      end
      if (start) begin
         c_ff  <= centre;
         p_ff  <= p_in;
         sh_ff <= {light.gain, 6'b0};
         for (int i = 0; i < 3; i++) begin
            lg_ff[i] <= lg_in[i];
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (stg_ff[0]) q_ff[i] <= q_in[i];
         if (stg_ff[1]) prod_ff[i] <= prod_in[i];
         if (stg_ff[2]) res_ff[i] <= res_in[i];
      end
   end

   assign done  = stg_ff[3];
   assign red   = res_ff[0];
   assign green = res_ff[1];
   assign blue  = res_ff[2];

endmodule
